@@ sv/weighted_graph_adjacency_store_unit_macros.svh @@
// Assertion macros for the weighted graph adjacency store.
// Used by the port checker; no other dependencies.
`ifndef WEIGHTED_GRAPH_ADJACENCY_STORE_UNIT_MACROS_SVH
`define WEIGHTED_GRAPH_ADJACENCY_STORE_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define WGAS_ASSERT_NOW(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("wgas check failed");

// Next-cycle implication, masked while reset is asserted
`define WGAS_ASSERT_NEXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("wgas check failed");

`endif

@@ sv/wgas_pkg.sv @@
// Shared constants, codes and control types for the graph adjacency store.
// No dependencies; every file but the RAM and the macro header imports this package.
package wgas_pkg;

  // Geometry
  localparam int MAX_V    = 16;
  localparam int SLOT_W   = $clog2(MAX_V);
  localparam int ENT_N    = MAX_V * MAX_V;
  localparam int ADDR_W   = 2 * SLOT_W;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int KEY_W    = 32;
  localparam int WEIGHT_W = 16;
  localparam int DEG_W    = 5;
  localparam int STR_W    = 19;
  localparam int VCNT_W   = 5;
  localparam int EDGE_W   = 16;

  localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = CMD_W'(0),
    CMD_DEL = CMD_W'(1),
    CMD_SET = CMD_W'(2),
    CMD_CLR = CMD_W'(3),
    CMD_QRY = CMD_W'(4)
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EXEC,
    ST_WR_BA,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Controller to datapath strobes
  typedef struct packed {
    logic load_item;
    logic cnt_clr;
    logic search;
    logic add_vertex;
    logic del_vertex;
    logic wr_ab;
    logic wr_ba;
    logic clr_edge;
    logic edge_inc;
    logic edge_dec;
    logic scan_rd;
    logic set_ok;
    logic load_rsp;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             found_a;
    logic             found_b;
    logic             has_free;
    logic             cnt_last;
  } sts_t;

endpackage

@@ sv/wgas_cmd_if.sv @@
// Command channel: valid/ready handshake carrying one command item.
// Depends on wgas_pkg for field widths.
interface wgas_cmd_if import wgas_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic [KEY_W-1:0]           key_a;
  logic [KEY_W-1:0]           key_b;
  logic signed [WEIGHT_W-1:0] edge_weight;

  modport source (output valid, cmd, key_a, key_b, edge_weight, input ready);
  modport sink   (input valid, cmd, key_a, key_b, edge_weight, output ready);
endinterface

@@ sv/wgas_rsp_if.sv @@
// Result channel: valid/ready handshake carrying one result item.
// Depends on wgas_pkg for field widths.
interface wgas_rsp_if import wgas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [DEG_W-1:0]  degree;
  logic [STR_W-1:0]  strength;
  logic [VCNT_W-1:0] vertex_total;
  logic [EDGE_W-1:0] edge_total;

  modport source (output valid, ok, degree, strength, vertex_total, edge_total,
                  input ready);
  modport sink   (input valid, ok, degree, strength, vertex_total, edge_total,
                  output ready);
endinterface

@@ sv/wgas_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wgas_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/wgas_dp.sv @@
// Datapath: item registers, key table, slot and entry valid bits, weight RAM,
// counters, row accumulators and result register. Depends on wgas_pkg, wgas_ram.
module wgas_dp import wgas_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctl_t                       ctl_i,
  output sts_t                       sts_o,
  input  logic [CMD_W-1:0]           cmd_i,
  input  logic [KEY_W-1:0]           key_a_i,
  input  logic [KEY_W-1:0]           key_b_i,
  input  logic signed [WEIGHT_W-1:0] edge_weight_i,
  output logic                       ok_o,
  output logic [DEG_W-1:0]           degree_o,
  output logic [STR_W-1:0]           strength_o,
  output logic [VCNT_W-1:0]          vertex_total_o,
  output logic [EDGE_W-1:0]          edge_total_o
);

  // Item registers
  logic [CMD_W-1:0]    cmd_q;
  logic [KEY_W-1:0]    key_a_q;
  logic [KEY_W-1:0]    key_b_q;
  logic [WEIGHT_W-1:0] weight_q;

  // Slot state
  logic [KEY_W-1:0]    keys_q [MAX_V];
  logic [MAX_V-1:0]    slot_vld_q;
  logic [ENT_N-1:0]    ent_vld_q, ent_vld_d;

  // Search and scan
  logic [SLOT_W-1:0]   cnt_q;
  logic                found_a_q, found_b_q, has_free_q;
  logic [SLOT_W-1:0]   idx_a_q, idx_b_q, free_q;
  logic                hit_a, hit_b;
  logic                rd_pend_q, rd_vld_q;

  // Counters and accumulators
  logic [VCNT_W-1:0]   vcnt_q;
  logic [EDGE_W-1:0]   ecnt_q;
  logic                ok_q;
  logic [DEG_W-1:0]    deg_q;
  logic [STR_W-1:0]    str_q;

  // Result register
  logic                rsp_ok_q;
  logic [DEG_W-1:0]    rsp_deg_q;
  logic [STR_W-1:0]    rsp_str_q;
  logic [VCNT_W-1:0]   rsp_vcnt_q;
  logic [EDGE_W-1:0]   rsp_ecnt_q;

  // Weight RAM
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [WEIGHT_W-1:0] ram_rdata;
  logic                rd_pos;

  wgas_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (ENT_N)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (weight_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_we    = ctl_i.wr_ab | ctl_i.wr_ba;
  assign ram_waddr = ctl_i.wr_ab ? {idx_a_q, idx_b_q} : {idx_b_q, idx_a_q};
  assign ram_raddr = {idx_a_q, cnt_q};

  // Compare the slot under the counter against both keys
  assign hit_a = slot_vld_q[cnt_q] && (keys_q[cnt_q] == key_a_q);
  assign hit_b = slot_vld_q[cnt_q] && (keys_q[cnt_q] == key_b_q);

  // Returned entry counts when valid and strictly positive
  assign rd_pos = rd_pend_q && rd_vld_q && !ram_rdata[WEIGHT_W-1] && (ram_rdata != '0);

  // Entry valid bits: set on write, drop on clear or vertex removal
  always_comb begin
    ent_vld_d = ent_vld_q;
    if (ctl_i.wr_ab) begin
      ent_vld_d[{idx_a_q, idx_b_q}] = 1'b1;
    end
    if (ctl_i.wr_ba) begin
      ent_vld_d[{idx_b_q, idx_a_q}] = 1'b1;
    end
    if (ctl_i.clr_edge) begin
      ent_vld_d[{idx_a_q, idx_b_q}] = 1'b0;
      ent_vld_d[{idx_b_q, idx_a_q}] = 1'b0;
    end
    if (ctl_i.del_vertex) begin
      for (int j = 0; j < MAX_V; j++) begin
        ent_vld_d[{idx_a_q, SLOT_W'(j)}] = 1'b0;
        ent_vld_d[{SLOT_W'(j), idx_a_q}] = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      found_a_q  <= 1'b0;
      found_b_q  <= 1'b0;
      has_free_q <= 1'b0;
      slot_vld_q <= '0;
      ent_vld_q  <= '0;
      vcnt_q     <= '0;
      ecnt_q     <= '0;
      ok_q       <= 1'b0;
      deg_q      <= '0;
      str_q      <= '0;
      rd_pend_q  <= 1'b0;
    end else begin
      ent_vld_q <= ent_vld_d;
      rd_pend_q <= ctl_i.scan_rd;

      // Advance or restart the slot counter
      if (ctl_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (ctl_i.search || ctl_i.scan_rd) begin
        cnt_q <= cnt_q + SLOT_W'(1);
      end

      // Clear per-item flags and accumulators
      if (ctl_i.load_item) begin
        found_a_q  <= 1'b0;
        found_b_q  <= 1'b0;
        has_free_q <= 1'b0;
        ok_q       <= 1'b0;
        deg_q      <= '0;
        str_q      <= '0;
      end

      // Latch first matches and first free slot
      if (ctl_i.search) begin
        if (hit_a && !found_a_q) begin
          found_a_q <= 1'b1;
        end
        if (hit_b && !found_b_q) begin
          found_b_q <= 1'b1;
        end
        if (!slot_vld_q[cnt_q] && !has_free_q) begin
          has_free_q <= 1'b1;
        end
      end

      if (ctl_i.set_ok) begin
        ok_q <= 1'b1;
      end

      // Vertex bookkeeping
      if (ctl_i.add_vertex) begin
        slot_vld_q[free_q] <= 1'b1;
        vcnt_q             <= vcnt_q + VCNT_W'(1);
      end
      if (ctl_i.del_vertex) begin
        slot_vld_q[idx_a_q] <= 1'b0;
        if (vcnt_q != '0) begin
          vcnt_q <= vcnt_q - VCNT_W'(1);
        end
      end

      // Saturating edge counter
      if (ctl_i.edge_inc && (ecnt_q != EDGE_MAX)) begin
        ecnt_q <= ecnt_q + EDGE_W'(1);
      end
      if (ctl_i.edge_dec && (ecnt_q != '0)) begin
        ecnt_q <= ecnt_q - EDGE_W'(1);
      end

      // Accumulate degree and strength from the returned row entry
      if (rd_pos) begin
        deg_q <= deg_q + DEG_W'(1);
        str_q <= str_q + STR_W'(ram_rdata);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_item) begin
      cmd_q    <= cmd_i;
      key_a_q  <= key_a_i;
      key_b_q  <= key_b_i;
      weight_q <= edge_weight_i;
    end
    if (ctl_i.search) begin
      if (hit_a && !found_a_q) begin
        idx_a_q <= cnt_q;
      end
      if (hit_b && !found_b_q) begin
        idx_b_q <= cnt_q;
      end
      if (!slot_vld_q[cnt_q] && !has_free_q) begin
        free_q <= cnt_q;
      end
    end
    if (ctl_i.add_vertex) begin
      keys_q[free_q] <= key_a_q;
    end
    rd_vld_q <= ent_vld_q[{idx_a_q, cnt_q}] && slot_vld_q[cnt_q];
    if (ctl_i.load_rsp) begin
      rsp_ok_q   <= ok_q;
      rsp_deg_q  <= deg_q;
      rsp_str_q  <= str_q;
      rsp_vcnt_q <= vcnt_q;
      rsp_ecnt_q <= ecnt_q;
    end
  end

  assign sts_o.cmd      = cmd_q;
  assign sts_o.found_a  = found_a_q;
  assign sts_o.found_b  = found_b_q;
  assign sts_o.has_free = has_free_q;
  assign sts_o.cnt_last = (cnt_q == SLOT_W'(MAX_V - 1));

  assign ok_o           = rsp_ok_q;
  assign degree_o       = rsp_deg_q;
  assign strength_o     = rsp_str_q;
  assign vertex_total_o = rsp_vcnt_q;
  assign edge_total_o   = rsp_ecnt_q;

endmodule

@@ sv/wgas_ctrl.sv @@
// Controller: command sequencer and result valid flag.
// Depends on wgas_pkg for state, command codes and control structs.
module wgas_ctrl import wgas_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;
  logic   rsp_valid_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and strobes
  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    cmd_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          ctl_o.load_item = 1'b1;
          ctl_o.cnt_clr   = 1'b1;
          state_d         = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        ctl_o.search = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        unique case (cmd_e'(sts_i.cmd))
          CMD_ADD: begin
            if (!sts_i.found_a && sts_i.has_free) begin
              ctl_o.add_vertex = 1'b1;
              ctl_o.set_ok     = 1'b1;
            end
          end
          CMD_DEL: begin
            if (sts_i.found_a) begin
              ctl_o.del_vertex = 1'b1;
              ctl_o.set_ok     = 1'b1;
            end
          end
          CMD_SET: begin
            if (sts_i.found_a && sts_i.found_b) begin
              ctl_o.wr_ab    = 1'b1;
              ctl_o.edge_inc = 1'b1;
              ctl_o.set_ok   = 1'b1;
              state_d        = ST_WR_BA;
            end
          end
          CMD_CLR: begin
            if (sts_i.found_a && sts_i.found_b) begin
              ctl_o.clr_edge = 1'b1;
              ctl_o.edge_dec = 1'b1;
              ctl_o.set_ok   = 1'b1;
            end
          end
          CMD_QRY: begin
            if (sts_i.found_a) begin
              ctl_o.set_ok  = 1'b1;
              ctl_o.cnt_clr = 1'b1;
              state_d       = ST_SCAN;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_WR_BA: begin
        ctl_o.wr_ba = 1'b1;
        state_d     = ST_DONE;
      end
      ST_SCAN: begin
        ctl_o.scan_rd = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Hand over once the result register is free
        if (!rsp_valid_q || rsp_ready_i) begin
          ctl_o.load_rsp = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid: set on load, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (ctl_o.load_rsp) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

@@ sv/weighted_graph_adjacency_store_unit.sv @@
// Keyed weighted graph store: 16-slot adjacency matrix, one item at a time.
// Each item steps through a key search over all slots, an execute step and a
// result step; set edge adds a second mirrored RAM write, a found query adds a row
// scan and a drain step for the last RAM read. A new item is taken only once the
// previous one has left its result step; an item waits in its last step while the
// previous result is not taken.
// Reset (async, active low) empties all slots and entries and zeroes both counters.
module weighted_graph_adjacency_store_unit import wgas_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  wgas_cmd_if.sink   cmd_i,
  wgas_rsp_if.source rsp_o
);

  ctl_t ctl;
  sts_t sts;

  wgas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  wgas_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .cmd_i          (cmd_i.cmd),
    .key_a_i        (cmd_i.key_a),
    .key_b_i        (cmd_i.key_b),
    .edge_weight_i  (cmd_i.edge_weight),
    .ok_o           (rsp_o.ok),
    .degree_o       (rsp_o.degree),
    .strength_o     (rsp_o.strength),
    .vertex_total_o (rsp_o.vertex_total),
    .edge_total_o   (rsp_o.edge_total)
  );

endmodule

@@ sv/wgas_checker.sv @@
// Port-level checker for the graph adjacency store, bound to the top level.
// Depends on wgas_pkg and the assertion macro header.
`include "weighted_graph_adjacency_store_unit_macros.svh"

module wgas_checker import wgas_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cmd_valid_i,
  input logic              cmd_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic              rsp_ok_i,
  input logic [DEG_W-1:0]  rsp_degree_i,
  input logic [STR_W-1:0]  rsp_strength_i,
  input logic [VCNT_W-1:0] rsp_vertex_total_i
);

  logic       cmd_acc, rsp_acc;
  logic [1:0] outst_q;

  assign cmd_acc = cmd_valid_i && cmd_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  // Track items accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (cmd_acc && !rsp_acc) begin
      outst_q <= outst_q + 2'd1;
    end else if (rsp_acc && !cmd_acc) begin
      outst_q <= outst_q - 2'd1;
    end
  end

  `WGAS_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `WGAS_ASSERT_NOW(a_rsp_has_item, clk_i, rst_ni, rsp_valid_i, outst_q != 2'd0)
  `WGAS_ASSERT_NOW(a_two_in_flight, clk_i, rst_ni, cmd_acc, outst_q <= 2'd1)
  `WGAS_ASSERT_NOW(a_degree_ok, clk_i, rst_ni, rsp_valid_i && (rsp_degree_i != '0), rsp_ok_i && (rsp_strength_i != '0))
  `WGAS_ASSERT_NOW(a_vertex_bound, clk_i, rst_ni, rsp_valid_i, rsp_vertex_total_i <= VCNT_W'(MAX_V))

endmodule

bind weighted_graph_adjacency_store_unit wgas_checker u_wgas_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .cmd_valid_i        (cmd_i.valid),
  .cmd_ready_i        (cmd_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_ok_i           (rsp_o.ok),
  .rsp_degree_i       (rsp_o.degree),
  .rsp_strength_i     (rsp_o.strength),
  .rsp_vertex_total_i (rsp_o.vertex_total)
);

@@ tb/weighted_graph_adjacency_store_unit_tb.sv @@
// Self-checking testbench for weighted_graph_adjacency_store_unit.
// Drives the command channel, tracks an adjacency-matrix model of the graph
// and checks every result item; depends on wgas_pkg, wgas_cmd_if and wgas_rsp_if.
module weighted_graph_adjacency_store_unit_tb;
  import wgas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 2;
  localparam int RESET_CYCLES  = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 60;
  localparam int POOL_N        = 24;

  localparam logic [KEY_W-1:0]    KEY_ALL_ONES = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0]    KEY_ABSENT   = 32'h5A5A_0001;
  localparam logic signed [WEIGHT_W-1:0] W_MAX = 16'sh7FFF;
  localparam logic signed [WEIGHT_W-1:0] W_MIN = 16'sh8000;
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_W'(int'(CMD_QRY) + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = {CMD_W{1'b1}};

  typedef struct packed {
    logic              ok;
    logic [DEG_W-1:0]  degree;
    logic [STR_W-1:0]  strength;
    logic [VCNT_W-1:0] vertex_total;
    logic [EDGE_W-1:0] edge_total;
  } graph_rsp_t;

  // Shadow copy of the graph: predicts each result and checks arrivals
  class graph_shadow;
    logic [KEY_W-1:0]           slot_key  [MAX_V];
    bit                         slot_used [MAX_V];
    logic signed [WEIGHT_W-1:0] weights   [MAX_V][MAX_V];
    int                         vertex_cnt;
    logic [EDGE_W-1:0]          edge_cnt;
    graph_rsp_t                 expected_rsps[$];
    int                         mismatch_cnt;

    function new();
      for (int i = 0; i < MAX_V; i++) begin
        slot_key[i]  = '0;
        slot_used[i] = 1'b0;
        for (int j = 0; j < MAX_V; j++) weights[i][j] = '0;
      end
      vertex_cnt   = 0;
      edge_cnt     = '0;
      mismatch_cnt = 0;
    endfunction

    function int lookup_slot(logic [KEY_W-1:0] key);
      for (int i = 0; i < MAX_V; i++) begin
        if (slot_used[i] && slot_key[i] == key) return i;
      end
      return -1;
    endfunction

    // Apply one accepted command and queue the result it must produce
    function void apply_cmd(logic [CMD_W-1:0] op, logic [KEY_W-1:0] ka,
                            logic [KEY_W-1:0] kb, logic signed [WEIGHT_W-1:0] w);
      int a;
      int b;
      int deg;
      int sum;
      logic signed [WEIGHT_W-1:0] nw;
      graph_rsp_t r;
      r = '0;
      a = lookup_slot(ka);
      b = lookup_slot(kb);
      case (op)
        CMD_ADD: begin
          if (a < 0) begin
            for (int j = 0; j < MAX_V; j++) begin
              if (!slot_used[j]) begin
                slot_used[j] = 1'b1;
                slot_key[j]  = ka;
                vertex_cnt++;
                r.ok = 1'b1;
                break;
              end
            end
          end
        end
        CMD_DEL: begin
          if (a >= 0) begin
            for (int j = 0; j < MAX_V; j++) begin
              weights[a][j] = '0;
              weights[j][a] = '0;
            end
            slot_used[a] = 1'b0;
            if (vertex_cnt > 0) vertex_cnt--;
            r.ok = 1'b1;
          end
        end
        CMD_SET, CMD_CLR: begin
          if (a >= 0 && b >= 0) begin
            nw = (op == CMD_SET) ? w : '0;
            weights[a][b] = nw;
            weights[b][a] = nw;
            // Saturate the edge counter at both ends
            if (op == CMD_SET) begin
              if (edge_cnt != EDGE_MAX) edge_cnt++;
            end else if (edge_cnt != '0) begin
              edge_cnt--;
            end
            r.ok = 1'b1;
          end
        end
        CMD_QRY: begin
          if (a >= 0) begin
            deg = 0;
            sum = 0;
            for (int j = 0; j < MAX_V; j++) begin
              if (slot_used[j] && weights[a][j] > 0) begin
                deg++;
                sum += weights[a][j];
              end
            end
            r.degree   = deg[DEG_W-1:0];
            r.strength = sum[STR_W-1:0];
            r.ok       = 1'b1;
          end
        end
        default: ;
      endcase
      r.vertex_total = vertex_cnt[VCNT_W-1:0];
      r.edge_total   = edge_cnt;
      expected_rsps.insert(expected_rsps.size(), r);
    endfunction

    task flag_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("MISMATCH %s: got %0h, want %0h", what, got, want);
      mismatch_cnt++;
    endtask

    // Compare one result item against the oldest prediction
    task check_rsp(graph_rsp_t got);
      graph_rsp_t want;
      if (expected_rsps.size() == 0) begin
        flag_mismatch("unexpected result", got, 0);
      end else begin
        want = expected_rsps.pop_front();
        if (got.ok !== want.ok) flag_mismatch("ok", got.ok, want.ok);
        if (got.degree !== want.degree) flag_mismatch("degree", got.degree, want.degree);
        if (got.strength !== want.strength) begin
          flag_mismatch("strength", got.strength, want.strength);
        end
        if (got.vertex_total !== want.vertex_total) begin
          flag_mismatch("vertex_total", got.vertex_total, want.vertex_total);
        end
        if (got.edge_total !== want.edge_total) begin
          flag_mismatch("edge_total", got.edge_total, want.edge_total);
        end
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  wgas_cmd_if cmd_if ();
  wgas_rsp_if rsp_if ();

  weighted_graph_adjacency_store_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  graph_shadow      shadow;
  int               src_idle_pct = 32;
  int               snk_idle_pct = 71;
  int               stall_cycles = 0;
  logic [KEY_W-1:0] key_pool[POOL_N];

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  // Toggle result ready at random on each falling edge
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Check each accepted result item
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      shadow.check_rsp(graph_rsp_t'{rsp_if.ok, rsp_if.degree, rsp_if.strength,
                                    rsp_if.vertex_total, rsp_if.edge_total});
    end
  end

  // Abort when neither channel moves an item for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("weighted_graph_adjacency_store_unit_tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one command, idling at random first, and hold until accepted
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] ka,
                          input logic [KEY_W-1:0] kb,
                          input logic signed [WEIGHT_W-1:0] w);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid       = 1'b1;
    cmd_if.cmd         = op;
    cmd_if.key_a       = ka;
    cmd_if.key_b       = kb;
    cmd_if.edge_weight = w;
    do @(posedge clk_i); while (!cmd_if.ready);
    shadow.apply_cmd(op, ka, kb, w);
  endtask

  // Hold off new commands until every outstanding result has arrived
  task automatic drain_results();
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
    while (shadow.expected_rsps.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom();
    return key_pool[$urandom_range(POOL_N - 1)];
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] pick_weight();
    if ($urandom_range(3) != 0) return WEIGHT_W'($urandom_range(1, int'(W_MAX)));
    return WEIGHT_W'($urandom());
  endfunction

  // Mostly commands on pooled keys so that lookups hit; some noise
  task automatic send_random_cmd();
    int               roll;
    logic [CMD_W-1:0] op;
    roll = $urandom_range(99);
    if (roll < 22)      op = CMD_ADD;
    else if (roll < 32) op = CMD_DEL;
    else if (roll < 62) op = CMD_SET;
    else if (roll < 72) op = CMD_CLR;
    else if (roll < 95) op = CMD_QRY;
    else op = CMD_W'($urandom_range(int'(CMD_UNUSED_LAST), int'(CMD_UNUSED_FIRST)));
    send_cmd(op, pick_key(), pick_key(), pick_weight());
    if ($urandom_range(99) == 0) drain_results();
  endtask

  initial begin
    shadow             = new();
    rst_ni             = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.cmd         = CMD_ADD;
    cmd_if.key_a       = '0;
    cmd_if.key_b       = '0;
    cmd_if.edge_weight = '0;
    key_pool[0] = '0;
    key_pool[1] = KEY_ALL_ONES;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, extreme keys and weights, diagonal, counter floor
    send_cmd(CMD_QRY, '0, '0, '0);
    send_cmd(CMD_CLR, '0, '0, '0);
    send_cmd(CMD_ADD, '0, '0, '0);
    send_cmd(CMD_ADD, KEY_ALL_ONES, '0, '0);
    send_cmd(CMD_ADD, '0, '0, '0);
    send_cmd(CMD_SET, '0, KEY_ALL_ONES, W_MAX);
    send_cmd(CMD_SET, '0, '0, W_MIN);
    send_cmd(CMD_SET, KEY_ALL_ONES, KEY_ALL_ONES, W_MAX);
    send_cmd(CMD_SET, '0, KEY_ABSENT, W_MAX);
    send_cmd(CMD_QRY, '0, '0, '0);
    send_cmd(CMD_QRY, KEY_ALL_ONES, '0, '0);
    send_cmd(CMD_CLR, '0, KEY_ALL_ONES, '0);
    send_cmd(CMD_CLR, KEY_ALL_ONES, KEY_ALL_ONES, '0);
    send_cmd(CMD_CLR, '0, '0, '0);
    send_cmd(CMD_CLR, '0, '0, '0);
    send_cmd(CMD_CLR, KEY_ABSENT, '0, '0);
    send_cmd(CMD_SET, '0, KEY_ALL_ONES, 16'sh0001);
    send_cmd(CMD_DEL, KEY_ALL_ONES, '0, '0);
    send_cmd(CMD_DEL, KEY_ALL_ONES, '0, '0);
    send_cmd(CMD_QRY, '0, '0, '0);
    send_cmd(CMD_QRY, KEY_ABSENT, KEY_ALL_ONES, W_MIN);
    for (int c = int'(CMD_UNUSED_FIRST); c <= int'(CMD_UNUSED_LAST); c++) begin
      send_cmd(CMD_W'(c), KEY_ALL_ONES, KEY_ALL_ONES, W_MAX);
    end

    // Random: sender idles at times, receiver stalls often
    repeat (600) send_random_cmd();
    drain_results();

    // Random: roles swapped
    src_idle_pct = 71;
    snk_idle_pct = 32;
    repeat (600) send_random_cmd();
    drain_results();

    // Random: full throughput
    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (500) send_random_cmd();
    drain_results();

    // Repeat sets on one self-loop, then clear it and query again
    send_cmd(CMD_DEL, key_pool[2], '0, '0);
    send_cmd(CMD_ADD, key_pool[2], '0, '0);
    repeat (3) send_cmd(CMD_SET, key_pool[2], key_pool[2], W_MAX);
    send_cmd(CMD_QRY, key_pool[2], '0, '0);
    send_cmd(CMD_CLR, key_pool[2], key_pool[2], '0);
    send_cmd(CMD_QRY, key_pool[2], '0, '0);

    // Wait out outstanding results plus a tail for strays
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (shadow.mismatch_cnt == 0 && shadow.expected_rsps.size() == 0) begin
      $display("weighted_graph_adjacency_store_unit_tb: clean");
    end else begin
      $display("weighted_graph_adjacency_store_unit_tb: errors");
    end
    $finish;
  end

endmodule
